FILE: rtl/core/pcsp_pkg.sv
// Package for the partition counting-sort permuter.
// Holds request codes, controller states and the request/result beat types.
// No dependencies.
package pcsp_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_TALLY = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_PLACE = 2'd3
    } t_req_kind;

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_NODE    = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_TALLY,
        S_PLACE,
        S_CLOSE
    } t_state;

    // One request beat
    typedef struct packed {
        t_req_kind  req_type;
        logic [6:0] part_id;
    } t_request;

    // One result beat
    typedef struct packed {
        logic        kind;
        logic [5:0]  part_index;
        logic [16:0] part_count;
        logic [16:0] part_offset;
        logic [16:0] position;
        logic        error;
        logic        last;
    } t_result;

endpackage

FILE: rtl/core/pcsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for every table of the partition counting-sort permuter. No dependencies.
module pcsp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/partition_counting_sort_permuter.sv
// Top level of the partition counting-sort permuter: stable counting sort of
// nodes by partition id. Depends on pcsp_pkg and pcsp_ram.
//
//   channel   | ports                      | handshake
//   ----------+----------------------------+-------------------------------
//   request   | i_req, start, busy         | beat taken when start & !busy
//   result    | o_res, o_res_valid         | one-cycle strobe, no back-pressure
//   config    | i_cfg_we, i_cfg_wdata      | written when i_cfg_we is high
//
// Clear, and any request rejected for a bad id or node overflow, leaves the block idle.
// Tally and place do one memory read, then the write-back.
// Close walks the np partitions in use, one count read per cycle.
// Reset is synchronous, active low; table contents are masked by per-entry
// valid bits that reset and clear drop at once, so there is no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.
module partition_counting_sort_permuter #(
    parameter int MAX_PARTS = 64,
    parameter int MAX_NODES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pcsp_pkg::t_request  i_req,
    output logic                o_res_valid,
    output pcsp_pkg::t_result   o_res,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata
);

    import pcsp_pkg::*;

    localparam int IW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_NODES + 1);

    // State and registers
    t_state                r_state, n_state;
    logic [IW-1:0]         r_p, n_p;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_last_idx, n_last_idx;
    logic [CW-1:0]         r_run, n_run;
    logic [CW-1:0]         r_node_total, n_node_total;
    logic [6:0]            r_num_parts;
    logic [MAX_PARTS-1:0]  r_val_cnt, n_val_cnt;
    logic [MAX_PARTS-1:0]  r_val_sf, n_val_sf;
    logic                  r_cnt_ok, r_sf_ok;
    logic                  r_res_valid, n_res_valid;
    t_result               r_res, n_res;

    // Memory ports
    logic [IW-1:0]         rd_addr, wr_addr;
    logic                  we_cnt, we_sf;
    logic [CW-1:0]         wd_cnt, q_cnt;
    logic [2*CW-1:0]       wd_sf, q_sf;

    // Request decode
    logic                  req_acc;
    logic [8:0]            np_w;
    logic                  id_ok;
    logic [IW-1:0]         p_in;
    logic [IW-1:0]         last_idx_in;
    logic                  tally_err;
    logic [CW-1:0]         cnt_q, start_q, fill_q;
    logic [CW:0]           end_q;
    logic                  close_last;

    pcsp_ram #(.WIDTH(CW), .DEPTH(MAX_PARTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (we_cnt),
        .i_waddr (wr_addr),
        .i_wdata (wd_cnt),
        .i_raddr (rd_addr),
        .o_rdata (q_cnt)
    );

    pcsp_ram #(.WIDTH(2*CW), .DEPTH(MAX_PARTS)) u_sf_ram (
        .i_clk   (i_clk),
        .i_we    (we_sf),
        .i_waddr (wr_addr),
        .i_wdata (wd_sf),
        .i_raddr (rd_addr),
        .o_rdata (q_sf)
    );

    assign busy    = (r_state != S_IDLE);
    assign req_acc = start && !busy;

    // Clamp partitions in use and check the id against it
    always_comb begin
        if (r_num_parts == 7'd0) begin
            np_w = 9'd1;
        end else if ({2'b00, r_num_parts} > 9'(MAX_PARTS)) begin
            np_w = 9'(MAX_PARTS);
        end else begin
            np_w = {2'b00, r_num_parts};
        end
    end

    assign id_ok       = (i_req.part_id != 7'd0) && ({2'b00, i_req.part_id} <= np_w);
    assign p_in        = id_ok ? IW'(i_req.part_id - 7'd1) : '0;
    assign last_idx_in = IW'(np_w - 9'd1);
    assign tally_err   = !id_ok || (r_node_total == CW'(MAX_NODES));

    // Mask entries never written since reset or clear
    assign cnt_q      = r_cnt_ok ? q_cnt : '0;
    assign start_q    = r_sf_ok ? q_sf[2*CW-1:CW] : '0;
    assign fill_q     = r_sf_ok ? q_sf[CW-1:0] : '0;
    assign end_q      = {1'b0, start_q} + {1'b0, cnt_q};
    assign close_last = (r_idx == r_last_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    unique case (i_req.req_type)
                        REQ_CLEAR: n_state = S_IDLE;
                        REQ_TALLY: n_state = tally_err ? S_IDLE : S_TALLY;
                        REQ_CLOSE: n_state = S_CLOSE;
                        REQ_PLACE: n_state = id_ok ? S_PLACE : S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TALLY: n_state = S_IDLE;
            S_PLACE: n_state = S_IDLE;
            S_CLOSE: begin
                if (close_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_p          = r_p;
        n_idx        = r_idx;
        n_last_idx   = r_last_idx;
        n_run        = r_run;
        n_node_total = r_node_total;
        n_val_cnt    = r_val_cnt;
        n_val_sf     = r_val_sf;
        n_res_valid  = 1'b0;
        n_res        = '0;
        rd_addr      = p_in;
        wr_addr      = r_p;
        we_cnt       = 1'b0;
        we_sf        = 1'b0;
        wd_cnt       = CW'(cnt_q + 1'b1);
        wd_sf        = {start_q, CW'(fill_q + 1'b1)};
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    unique case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_node_total = '0;
                            n_val_cnt    = '0;
                            n_val_sf     = '0;
                        end
                        REQ_TALLY: begin
                            if (tally_err) begin
                                n_res_valid = 1'b1;
                                n_res.kind  = KIND_NODE;
                                n_res.error = 1'b1;
                                n_res.last  = 1'b1;
                            end else begin
                                n_p          = p_in;
                                n_node_total = CW'(r_node_total + 1'b1);
                            end
                        end
                        REQ_CLOSE: begin
                            n_idx      = '0;
                            n_last_idx = last_idx_in;
                            n_run      = '0;
                            rd_addr    = '0;
                        end
                        REQ_PLACE: begin
                            if (!id_ok) begin
                                n_res_valid = 1'b1;
                                n_res.kind  = KIND_NODE;
                                n_res.error = 1'b1;
                                n_res.last  = 1'b1;
                            end else begin
                                n_p = p_in;
                            end
                        end
                        default: begin
                            n_p = r_p;
                        end
                    endcase
                end
            end
            S_TALLY: begin
                // Write back the incremented count
                we_cnt         = 1'b1;
                n_val_cnt[r_p] = 1'b1;
            end
            S_PLACE: begin
                n_res_valid = 1'b1;
                n_res.kind  = KIND_NODE;
                n_res.last  = 1'b1;
                if ({1'b0, fill_q} >= end_q) begin
                    // Partition already full: report and leave state alone
                    n_res.error = 1'b1;
                end else begin
                    n_res.position = 17'(fill_q + 1'b1);
                    we_sf          = 1'b1;
                    n_val_sf[r_p]  = 1'b1;
                end
            end
            S_CLOSE: begin
                // Emit one summary and set start and fill of this partition
                n_res_valid      = 1'b1;
                n_res.kind       = KIND_SUMMARY;
                n_res.part_index = 6'(r_idx);
                n_res.part_count = 17'(cnt_q);
                n_res.part_offset = 17'(r_run);
                n_res.last       = close_last;
                wr_addr          = r_idx;
                we_sf            = 1'b1;
                wd_sf            = {r_run, r_run};
                n_val_sf[r_idx]  = 1'b1;
                n_run            = CW'(r_run + cnt_q);
                if (!close_last) begin
                    n_idx   = IW'(r_idx + 1'b1);
                    rd_addr = IW'(r_idx + 1'b1);
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_total <= '0;
            r_num_parts  <= 7'd1;
            r_val_cnt    <= '0;
            r_val_sf     <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_total <= n_node_total;
            r_val_cnt    <= n_val_cnt;
            r_val_sf     <= n_val_sf;
            r_res_valid  <= n_res_valid;
            if (i_cfg_we) begin
                r_num_parts <= i_cfg_wdata;
            end
        end
    end

    // Payload registers; valid flags follow the read address
    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_run      <= n_run;
        r_res      <= n_res;
        r_cnt_ok   <= r_val_cnt[rd_addr];
        r_sf_ok    <= r_val_sf[rd_addr];
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Node total never runs past its limit
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_total <= CW'(MAX_NODES))
        else $error("node total above limit");

    // Error beats carry no position and end their run
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.error |-> (o_res.position == 17'd0) && o_res.last
            && (o_res.kind == KIND_NODE))
        else $error("malformed error beat");

    // Close walk stays within the partitions in use
    a_close_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLOSE |-> r_idx <= r_last_idx)
        else $error("close index past last partition");

    // Place always answers in the cycle after S_PLACE
    a_place_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PLACE |=> o_res_valid && (o_res.kind == KIND_NODE)
            && (r_state == S_IDLE))
        else $error("place produced no result");

    // Tally write-back emits nothing and returns to idle
    a_tally_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TALLY |=> !o_res_valid && (r_state == S_IDLE))
        else $error("tally write-back misbehaved");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the partition counting-sort permuter.
// Drives clear/tally/close/place requests and checks every result beat against
// an in-bench model of the sort state. Depends on pcsp_pkg and the top level.
module testbench;
    import pcsp_pkg::*;

    localparam int MAX_PARTS       = 64;
    localparam int MAX_NODES       = 65536;
    localparam int RANDOM_ITEMS    = 330;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_CYCLES = 2000;

    // One row of the directed script: a request, or a write of num_parts
    typedef struct {
        bit        is_cfg;
        t_req_kind kind;
        int        id;
        bit        typed;
        t_result   want;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    logic      busy;
    t_request  i_req       = '0;
    logic      o_res_valid;
    t_result   o_res;
    logic      i_cfg_we    = 1'b0;
    logic [6:0] i_cfg_wdata = '0;

    // Typed expectation that travels with the request beat it belongs to
    bit        row_typed  = 1'b0;
    t_result   row_result = '0;

    // Model of the sort tables
    int        tally_counts [MAX_PARTS];
    int        slot_starts  [MAX_PARTS];
    int        slot_fills   [MAX_PARTS];
    int        tallied_nodes;
    int        parts_cfg;
    t_result   due_results [$];

    t_row      directed_rows [$];
    bit        no_gaps      = 1'b0;
    int        active_parts = 1;
    int        items_sent   = 0;
    int        result_beats = 0;
    int        close_sweeps = 0;
    int        error_beats  = 0;
    int        mismatches   = 0;
    int        quiet_cycles = 0;

    partition_counting_sort_permuter #(
        .MAX_PARTS(MAX_PARTS),
        .MAX_NODES(MAX_NODES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (result beat %0d)",
                 what, got, want, result_beats);
        mismatches++;
    endtask

    function automatic t_result node_beat(int pos, bit err);
        t_result b;
        b          = '0;
        b.kind     = KIND_NODE;
        b.position = 17'(pos);
        b.error    = err;
        b.last     = 1'b1;
        return b;
    endfunction

    // Check result beats, track num_parts, and predict each accepted request
    always @(posedge i_clk) begin : sort_monitor
        int      np;
        int      id;
        int      p;
        int      run;
        int      n_before;
        bit      id_ok;
        t_result got;
        t_result want;
        t_result beat;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PARTS; i++) begin
                tally_counts[i] = 0;
                slot_starts[i]  = 0;
                slot_fills[i]   = 0;
            end
            tallied_nodes = 0;
            parts_cfg     = 1;
        end else begin
            // compare the result beat with the oldest one due
            if (o_res_valid) begin
                got = o_res;
                result_beats++;
                if (due_results.size() == 0) begin
                    report_mismatch("result beat with nothing due", 0, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.part_index !== want.part_index)
                        report_mismatch("part_index", got.part_index, want.part_index);
                    if (got.part_count !== want.part_count)
                        report_mismatch("part_count", got.part_count, want.part_count);
                    if (got.part_offset !== want.part_offset)
                        report_mismatch("part_offset", got.part_offset, want.part_offset);
                    if (got.position !== want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.error !== want.error)
                        report_mismatch("error", got.error, want.error);
                    if (got.last !== want.last)
                        report_mismatch("last", got.last, want.last);
                    if (want.error)
                        error_beats++;
                end
            end

            if (i_cfg_we)
                parts_cfg = i_cfg_wdata;

            // predict the results of the request beat taken at this edge
            if (start && !busy) begin
                np       = (parts_cfg == 0) ? 1 : (parts_cfg > MAX_PARTS) ? MAX_PARTS
                                                                          : parts_cfg;
                id       = i_req.part_id;
                id_ok    = (id >= 1) && (id <= np);
                p        = id_ok ? id - 1 : 0;
                n_before = due_results.size();
                case (i_req.req_type)
                    REQ_CLEAR: begin
                        for (int i = 0; i < MAX_PARTS; i++) begin
                            tally_counts[i] = 0;
                            slot_starts[i]  = 0;
                            slot_fills[i]   = 0;
                        end
                        tallied_nodes = 0;
                    end
                    REQ_TALLY: begin
                        if (!id_ok || tallied_nodes >= MAX_NODES) begin
                            due_results.push_back(node_beat(0, 1'b1));
                        end else begin
                            tally_counts[p]++;
                            tallied_nodes++;
                        end
                    end
                    REQ_CLOSE: begin
                        run = 0;
                        for (int i = 0; i < np; i++) begin
                            slot_starts[i]   = run;
                            slot_fills[i]    = run;
                            beat             = '0;
                            beat.kind        = KIND_SUMMARY;
                            beat.part_index  = 6'(i);
                            beat.part_count  = 17'(tally_counts[i]);
                            beat.part_offset = 17'(run);
                            beat.last        = (i == np - 1);
                            due_results.push_back(beat);
                            run += tally_counts[i];
                        end
                        close_sweeps++;
                    end
                    REQ_PLACE: begin
                        if (!id_ok || slot_fills[p] >= slot_starts[p] + tally_counts[p]) begin
                            due_results.push_back(node_beat(0, 1'b1));
                        end else begin
                            due_results.push_back(node_beat(slot_fills[p] + 1, 1'b0));
                            slot_fills[p]++;
                        end
                    end
                    default: ;
                endcase
                // a typed row replaces the single predicted beat
                if (row_typed && due_results.size() == n_before + 1)
                    due_results[$] = row_result;
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid || (start && !busy))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("watchdog: no beat for %0d cycles, %0d results still due",
                     WATCHDOG_CYCLES, due_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Send one request beat after a random gap (none in no-gap mode) and wait until it is taken
    task automatic send_item(t_req_kind kind, int id, bit typed = 1'b0,
                             t_result want = '0);
        t_request r;
        int       gap;
        r.req_type = kind;
        r.part_id  = 7'(id);
        gap        = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req      <= r;
        row_typed  <= typed;
        row_result <= want;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Hold off until every due result is back and the block has gone quiet
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_parts(int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 7'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_parts = (value == 0) ? 1 : (value > MAX_PARTS) ? MAX_PARTS : value;
    endtask

    task automatic add_req(t_req_kind kind, int id, bit typed = 1'b0,
                           t_result want = '0);
        t_row row;
        row = '{is_cfg: 1'b0, kind: kind, id: id, typed: typed, want: want};
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(int value);
        t_row row;
        row = '{is_cfg: 1'b1, kind: REQ_CLEAR, id: value, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    initial begin : stimulus
        t_result err_beat;
        t_result one_summary;
        int      node_ids [$];
        int      n;
        int      pick;
        int      random_start;
        int      sort_passes;
        err_beat    = node_beat(0, 1'b1);
        one_summary = '0;
        one_summary.kind       = KIND_SUMMARY;
        one_summary.part_count = 17'd1;
        one_summary.last       = 1'b1;
        sort_passes = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script: empty tables, bad ids, clamped settings, over-placement
        add_req(REQ_PLACE, 1, 1'b1, err_beat);
        add_req(REQ_TALLY, 2, 1'b1, err_beat);
        add_req(REQ_TALLY, 0, 1'b1, err_beat);
        add_req(REQ_TALLY, 1);
        add_req(REQ_CLOSE, 0, 1'b1, one_summary);
        add_req(REQ_PLACE, 1, 1'b1, node_beat(1, 1'b0));
        add_req(REQ_PLACE, 1, 1'b1, err_beat);
        add_cfg(0);
        add_req(REQ_TALLY, 1);
        add_req(REQ_TALLY, 2, 1'b1, err_beat);
        add_cfg(127);
        add_req(REQ_CLEAR, 127);
        add_req(REQ_TALLY, 64);
        add_req(REQ_TALLY, 1);
        add_req(REQ_TALLY, 64);
        add_req(REQ_TALLY, 127, 1'b1, err_beat);
        add_req(REQ_TALLY, 65, 1'b1, err_beat);
        add_req(REQ_CLOSE, 64);
        add_req(REQ_PLACE, 64);
        add_req(REQ_PLACE, 1, 1'b1, node_beat(1, 1'b0));
        add_req(REQ_PLACE, 64);
        add_req(REQ_PLACE, 0, 1'b1, err_beat);
        add_req(REQ_TALLY, 32);
        add_req(REQ_PLACE, 32);
        add_cfg(64);
        add_req(REQ_CLOSE, 1);
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                settle();
                write_parts(directed_rows[k].id);
            end else begin
                send_item(directed_rows[k].kind, directed_rows[k].id,
                          directed_rows[k].typed, directed_rows[k].want);
            end
        end

        // random sort passes: clear, tallies, close, places in the same order
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (sort_passes == 0 || $urandom_range(0, 2) == 0) begin
                settle();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    write_parts(0);
                else if (pick == 1)
                    write_parts($urandom_range(65, 127));
                else if (pick < 6)
                    write_parts($urandom_range(1, 64));
                else
                    write_parts($urandom_range(1, 8));
            end
            no_gaps = ($urandom_range(0, 2) == 0);
            n = $urandom_range(1, 20);
            node_ids.delete();
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0)
                    node_ids.push_back($urandom_range(0, 127));
                else
                    node_ids.push_back($urandom_range(1, active_parts));
            end
            // skip the clear now and then to run on stale tables
            if ($urandom_range(0, 9) != 0)
                send_item(REQ_CLEAR, $urandom_range(0, 127));
            foreach (node_ids[k]) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(t_req_kind'($urandom_range(0, 3)), $urandom_range(0, 127));
                send_item(REQ_TALLY, node_ids[k]);
            end
            send_item(REQ_CLOSE, $urandom_range(0, 127));
            foreach (node_ids[k]) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(REQ_PLACE, $urandom_range(0, 127));
                else
                    send_item(REQ_PLACE, node_ids[k]);
            end
            // one place too many, usually over-placement
            if ($urandom_range(0, 3) == 0)
                send_item(REQ_PLACE, $urandom_range(1, active_parts));
            if ($urandom_range(0, 3) == 0)
                settle();
            sort_passes++;
        end

        settle();
        $display("covered %0d requests: the directed rows and %0d random sort passes",
                 items_sent, sort_passes);
        $display("checked %0d result beats: %0d close sweeps, %0d error beats, %0d mismatches",
                 result_beats, close_sweeps, error_beats, mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pcsp_pkg.sv
rtl/core/pcsp_ram.sv
rtl/core/partition_counting_sort_permuter.sv
sim/testbench.sv
